/* hdl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int COUNT_W   = 32;
	localparam int CAP_W     = 5;
	localparam int IDX_MAX_W = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		CELL_NOP,
		CELL_TOUCH,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [IDX_MAX_W-1:0]   slot;
		logic [IDX_MAX_W-1:0]   victim;
		logic [IDX_MAX_W-1:0]   rank;
		logic                   evict;
		logic                   is_put;
	} cell_cmd_t;

	typedef struct packed {
		logic                   have;
		logic [COUNT_W-1:0]     count;
		logic [IDX_MAX_W-1:0]   rank;
		logic [IDX_MAX_W-1:0]   idx;
	} best_t;

endpackage

/* hdl/lfu_ifs.sv */
// ----------------------------------------------------------------------------
// lfu_req_if / lfu_rsp_if
// Valid/ready channels for cache requests and responses.
// ----------------------------------------------------------------------------
interface lfu_req_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic signed [KEY_BITS-1:0]    lookup_key;
	logic signed [VALUE_BITS-1:0]  store_value;

	modport source (output valid, func, lookup_key, store_value, input ready);
	modport sink   (input valid, func, lookup_key, store_value, output ready);
endinterface

interface lfu_rsp_if #(
	parameter int VALUE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [VALUE_BITS-1:0]  read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink   (input valid, hit, read_value, output ready);
endinterface

/* hdl/lfu_cell.sv */
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry: key match, update on command, and one stage of the
// victim search chain.
// ----------------------------------------------------------------------------
module lfu_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int RANK_W     = 4,
	parameter int IDX        = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lfu_pkg::cell_cmd_t        cmd,
	input  logic [KEY_BITS-1:0]       req_key,
	input  logic [VALUE_BITS-1:0]     req_value,
	input  lfu_pkg::best_t            best_in,
	output lfu_pkg::best_t            best_out,
	output logic                      match,
	output logic                      valid,
	output logic [VALUE_BITS-1:0]     value,
	output logic [RANK_W-1:0]         rank
);

	logic                             valid_q;
	logic [KEY_BITS-1:0]              key_q;
	logic [VALUE_BITS-1:0]            val_q;
	logic [lfu_pkg::COUNT_W-1:0]      count_q;
	logic [RANK_W-1:0]                rank_q;
	lfu_pkg::best_t                   best_q;
	logic [lfu_pkg::IDX_MAX_W-1:0]    rank_ext;
	logic [lfu_pkg::IDX_MAX_W-1:0]    my_idx;
	logic                             better;
	logic                             is_slot;

	assign rank_ext = lfu_pkg::IDX_MAX_W'(rank_q);
	assign my_idx   = lfu_pkg::IDX_MAX_W'(IDX);
	assign match    = valid_q && (key_q == req_key);
	assign valid    = valid_q;
	assign value    = val_q;
	assign rank     = rank_q;
	assign best_out = best_q;
	assign is_slot  = (cmd.slot == my_idx);

	assign better = valid_q && (!best_in.have || (count_q < best_in.count) ||
		((count_q == best_in.count) && (rank_ext > best_in.rank)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (better) begin
			best_q <= '{have: 1'b1, count: count_q, rank: rank_ext, idx: my_idx};
		end else begin
			best_q <= best_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
			rank_q  <= '0;
		end else begin
			case (cmd.op)
				lfu_pkg::CELL_TOUCH: begin
					if (is_slot) begin
						if (count_q != '1)
							count_q <= count_q + 1'b1;
						rank_q <= '0;
					end else if (valid_q && rank_ext < cmd.rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				lfu_pkg::CELL_INSERT: begin
					if (is_slot) begin
						valid_q <= 1'b1;
						count_q <= lfu_pkg::COUNT_W'(1);
						rank_q  <= '0;
					end else if (cmd.evict && cmd.victim == my_idx) begin
						valid_q <= 1'b0;
					end else if (valid_q && (!cmd.evict || rank_ext < cmd.rank)) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_slot && cmd.op == lfu_pkg::CELL_INSERT) begin
			key_q <= req_key;
			val_q <= req_value;
		end else if (is_slot && cmd.op == lfu_pkg::CELL_TOUCH && cmd.is_put) begin
			val_q <= req_value;
		end
	end

endmodule

/* hdl/lfu_cache_lru_tiebreak_top.sv */
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top
// Fully associative LFU cache, ties to least recently used, as a row of cells.
// A request steps through match, a victim search on a put miss to a full cache,
// then update, which registers the response; a new request is taken only back in
// idle with the response slot free. The victim search walks the cell chain one cell per cycle.
// Reset clears all valid bits, counts, ranks and occupancy; capacity resets to 16.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_top #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lfu_req_if.sink                       req,
	lfu_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]     cfg_wdata
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {S_IDLE, S_MATCH, S_SCAN, S_UPDATE} state_t;

	state_t                         state_q;
	logic                           func_q;
	logic [KEY_BITS-1:0]            key_q;
	logic [VALUE_BITS-1:0]          val_q;
	logic                           hit_q;
	logic [IW-1:0]                  hit_idx_q;
	logic [lfu_pkg::IDX_MAX_W-1:0]  hit_rank_q;
	logic [VALUE_BITS-1:0]          hit_val_q;
	logic                           evict_q;
	logic [OW-1:0]                  scan_cnt_q;
	logic [OW-1:0]                  occ_q;
	logic [lfu_pkg::CAP_W-1:0]      cap_q;
	logic                           rsp_valid_q;
	logic                           rsp_hit_q;
	logic [VALUE_BITS-1:0]          rsp_val_q;

	lfu_pkg::cell_cmd_t             cmd;
	lfu_pkg::best_t                 chain [ENTRIES+1];
	lfu_pkg::best_t                 best;
	logic [ENTRIES-1:0]             match_vec;
	logic [ENTRIES-1:0]             valid_vec;
	logic [VALUE_BITS-1:0]          val_arr  [ENTRIES];
	logic [IW-1:0]                  rank_arr [ENTRIES];

	logic                           any_match;
	logic [IW-1:0]                  m_idx;
	logic [IW-1:0]                  free_idx;
	logic [31:0]                    cap_eff;
	logic                           evict_eff;
	logic                           accept;

	assign chain[0] = '0;
	assign best     = chain[ENTRIES];

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lfu_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.RANK_W     (IW),
			.IDX        (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.req_key   (key_q),
			.req_value (val_q),
			.best_in   (chain[g]),
			.best_out  (chain[g+1]),
			.match     (match_vec[g]),
			.valid     (valid_vec[g]),
			.value     (val_arr[g]),
			.rank      (rank_arr[g])
		);
	end

	always_comb begin
		any_match = 1'b0;
		m_idx     = '0;
		free_idx  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				any_match = 1'b1;
				m_idx     = IW'(i);
			end
			if (!valid_vec[i] || (evict_eff && best.idx == lfu_pkg::IDX_MAX_W'(i)))
				free_idx = IW'(i);
		end
	end

	always_comb begin
		if (cap_q == '0)
			cap_eff = 32'd1;
		else if (32'(cap_q) > 32'(ENTRIES))
			cap_eff = 32'(ENTRIES);
		else
			cap_eff = 32'(cap_q);
	end

	assign evict_eff = evict_q && best.have;
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		cmd = '0;
		if (state_q == S_UPDATE) begin
			cmd.is_put = func_q;
			if (hit_q) begin
				cmd.op   = lfu_pkg::CELL_TOUCH;
				cmd.slot = lfu_pkg::IDX_MAX_W'(hit_idx_q);
				cmd.rank = hit_rank_q;
			end else if (func_q) begin
				cmd.op     = lfu_pkg::CELL_INSERT;
				cmd.slot   = lfu_pkg::IDX_MAX_W'(free_idx);
				cmd.evict  = evict_eff;
				cmd.victim = best.idx;
				cmd.rank   = best.rank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q  <= req.lookup_key;
			val_q  <= req.store_value;
		end
		if (state_q == S_MATCH) begin
			hit_q      <= any_match;
			hit_idx_q  <= m_idx;
			hit_rank_q <= lfu_pkg::IDX_MAX_W'(rank_arr[m_idx]);
			hit_val_q  <= val_arr[m_idx];
			evict_q    <= !any_match && func_q && (32'(occ_q) >= cap_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_cnt_q  <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_hit_q   <= 1'b0;
			rsp_val_q   <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_MATCH;
				end
				S_MATCH: begin
					scan_cnt_q <= '0;
					if (!any_match && func_q && (32'(occ_q) >= cap_eff))
						state_q <= S_SCAN;
					else
						state_q <= S_UPDATE;
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == OW'(ENTRIES - 1))
						state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (!hit_q && func_q && !evict_eff)
						occ_q <= occ_q + 1'b1;
					rsp_valid_q <= 1'b1;
					rsp_hit_q   <= hit_q && !func_q;
					rsp_val_q   <= (hit_q && !func_q) ? hit_val_q : '1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_val_q;

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_vec)) == 32'(occ_q))
		else $error("occupancy differs from valid entries");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(ENTRIES))
		else $error("occupancy above entry count");

	a_rsp_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_UPDATE))
		else $error("response without update");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("key held in more than one entry");

endmodule
